>>> design/kss_pkg.sv
// shared types, constants and helpers of the k-sorted stream sorter
// no dependencies
`default_nettype none

package kss_pkg;

  localparam int unsigned STORE_DEPTH = 32;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned K_W         = 5;
  localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [K_W-1:0]           k_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample_value;
    logic                     end_of_sequence;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_output;
  } out_beat_t;

  typedef struct packed {
    logic pop;
    logic insert;
  } cell_ctrl_t;

  // k+1, saturated at the chain length
  function automatic cnt_t capacity(k_t k);
    int unsigned c;
    c = int'(k) + 1;
    if (c > STORE_DEPTH) begin
      c = STORE_DEPTH;
    end
    return CNT_W'(c);
  endfunction

endpackage

`default_nettype wire

>>> design/kss_cell.sv
// one slot of the sorted register chain: holds a value, shifts left on pop,
// takes the left neighbor or the new value on insert; uses kss_pkg
`default_nettype none

module kss_cell import kss_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occ_i,
  input  data_t      ins_val_i,
  input  logic       left_lt_i,
  input  data_t      left_val_i,
  input  data_t      right_val_i,
  output data_t      val_o,
  output logic       lt_o
);

  data_t val_q, val_d;

  assign lt_o  = occ_i && (ins_val_i < val_q);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.pop) begin
      val_d = right_val_i;
    end else if (ctrl_i.insert) begin
      if (left_lt_i) begin
        val_d = left_val_i;
      end else if (lt_o || !occ_i) begin
        val_d = ins_val_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

>>> design/k_sorted_stream_sorter_core.sv
// an item is accepted, with an optional pop, in the idle state, then inserted into the chain;
// no new item is taken until the last one has been inserted into the cell chain
// on the item marked last, one drained beat per cycle follows while the output is taken
// reset: count, state, output valid and k clear at once; chain data is not reset
// top level of the k-sorted stream sorter; uses kss_pkg and kss_cell
`default_nettype none

module k_sorted_stream_sorter_core import kss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o,
  input  logic      cfg_we_i,
  input  k_t        cfg_wdata_i
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_INSERT = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;

  logic [1:0] state_q, state_d;
  cnt_t       count_q, count_d;
  k_t         k_q;
  data_t      hold_val_q;
  logic       hold_last_q;
  logic       out_valid_q, out_valid_d;
  out_beat_t  out_q, out_d;

  cell_ctrl_t ctrl;
  logic       can_emit, need_pop, emit, emit_final, accept;

  data_t cell_val [STORE_DEPTH];
  logic  cell_lt  [STORE_DEPTH];

  assign can_emit = !out_valid_q || out_ready_i;
  assign need_pop = (count_q >= capacity(k_q)) && (count_q != '0);
  assign accept   = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ctrl       = '0;
    emit       = 1'b0;
    emit_final = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = !need_pop || can_emit;
        if (in_valid_i && in_ready_o) begin
          state_d = ST_INSERT;
          if (need_pop) begin
            emit     = 1'b1;
            ctrl.pop = 1'b1;
            count_d  = count_q - cnt_t'(1);
          end
        end
      end
      ST_INSERT: begin
        ctrl.insert = 1'b1;
        count_d     = count_q + cnt_t'(1);
        state_d     = hold_last_q ? ST_DRAIN : ST_IDLE;
      end
      ST_DRAIN: begin
        if (count_q == '0) begin
          state_d = ST_IDLE;
        end else if (can_emit) begin
          emit       = 1'b1;
          emit_final = (count_q == cnt_t'(1));
          ctrl.pop   = 1'b1;
          count_d    = count_q - cnt_t'(1);
          if (count_q == cnt_t'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (emit) begin
      out_valid_d        = 1'b1;
      out_d.sorted_value = cell_val[0];
      out_d.final_output = emit_final;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        k_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      hold_val_q  <= in_data_i.sample_value;
      hold_last_q <= in_data_i.end_of_sequence;
    end
  end

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    logic  left_lt;
    data_t left_val, right_val;
    if (i == 0) begin : g_first
      assign left_lt  = 1'b0;
      assign left_val = '0;
    end else begin : g_mid
      assign left_lt  = cell_lt[i-1];
      assign left_val = cell_val[i-1];
    end
    if (i == STORE_DEPTH - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end
    kss_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (cnt_t'(i) < count_q),
      .ins_val_i  (hold_val_q),
      .left_lt_i  (left_lt),
      .left_val_i (left_val),
      .right_val_i(right_val),
      .val_o      (cell_val[i]),
      .lt_o       (cell_lt[i])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(STORE_DEPTH))
    else $error("held count above chain length");

  a_accept_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_INSERT)
    else $error("accepted beat not followed by insert");

  a_final_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_final) |=> count_q == '0)
    else $error("final beat left values in the chain");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= cnt_t'(2)) |-> !(cell_val[1] < cell_val[0]))
    else $error("chain head out of order");

endmodule

`default_nettype wire

>>> tb/kss_stream_checker.sv
// checker for the k-sorted stream sorter: watches the config, input and output channels,
// predicts the sorted output beats and compares them in order
// depends on kss_pkg
module kss_stream_checker import kss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_beat_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_beat_t   out_data_i,
  input  logic        cfg_we_i,
  input  k_t          cfg_wdata_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned result_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  data_t       sorted_store [STORE_DEPTH];
  int unsigned held;
  k_t          k_reg;
  out_beat_t   expected_beats [$];
  int unsigned fails;
  int unsigned results;

  function automatic data_t take_min();
    data_t v;
    v = sorted_store[0];
    for (int unsigned i = 1; i < held; i++) begin
      sorted_store[i-1] = sorted_store[i];
    end
    held--;
    return v;
  endfunction

  function automatic void insert_value(data_t v);
    int unsigned pos;
    pos = held;
    while (pos > 0 && v < sorted_store[pos-1]) begin
      sorted_store[pos] = sorted_store[pos-1];
      pos--;
    end
    sorted_store[pos] = v;
    held++;
  endfunction

  function automatic void predict_beat(in_beat_t b);
    int unsigned cap;
    out_beat_t   o;
    cap = int'(k_reg) + 1;
    if (cap > STORE_DEPTH) begin
      cap = STORE_DEPTH;
    end
    if (held >= cap && held > 0) begin
      o.sorted_value = take_min();
      o.final_output = 1'b0;
      expected_beats = {expected_beats, o};
    end
    insert_value(b.sample_value);
    if (b.end_of_sequence) begin
      while (held > 0) begin
        o.sorted_value = take_min();
        o.final_output = (held == 0);
        expected_beats = {expected_beats, o};
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      held = 0;
      k_reg = '0;
      fails = 0;
      results = 0;
      expected_beats.delete();
      fail_count_o <= 0;
      pending_o <= 0;
      result_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results++;
        if (expected_beats.size() == 0) begin
          fails++;
          if (fails <= 100) begin
            $display("%0t: unexpected beat, expected none, actual value %0d final %0b",
                     $time, out_data_i.sorted_value, out_data_i.final_output);
          end
        end else begin
          want = expected_beats.pop_front();
          if (want.sorted_value !== out_data_i.sorted_value ||
              want.final_output !== out_data_i.final_output) begin
            fails++;
            if (fails <= 100) begin
              $display("%0t: mismatch, expected value %0d final %0b, actual value %0d final %0b",
                       $time, want.sorted_value, want.final_output,
                       out_data_i.sorted_value, out_data_i.final_output);
            end
          end
        end
      end
      if (cfg_we_i) begin
        k_reg = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) begin
        predict_beat(in_data_i);
      end
      fail_count_o <= fails;
      pending_o <= expected_beats.size();
      result_count_o <= results;
    end
  end

endmodule

>>> tb/testbench.sv
// top of the k-sorted stream sorter testbench: clock, reset, stimulus and verdict
// depends on kss_pkg, k_sorted_stream_sorter_core and kss_stream_checker
module testbench;
  import kss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_beat_t   out_data;
  logic        cfg_we = 1'b0;
  k_t          cfg_wdata = '0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned result_count;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned sent_count = 0;
  int unsigned k_writes = 0;

  k_sorted_stream_sorter_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  kss_stream_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_data_i     (out_data),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .result_count_o (result_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_beat(data_t v, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= '{sample_value: v, end_of_sequence: last};
    @(posedge clk_i);
    while (!in_ready) begin
      @(posedge clk_i);
    end
    sent_count++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_k(k_t val);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    k_writes++;
  endtask

  task automatic send_sequence(int unsigned len);
    data_t       vals [64];
    data_t       acc;
    data_t       tmp;
    int unsigned mode;
    int unsigned i;
    mode = $urandom_range(3);
    acc = $urandom;
    for (i = 0; i < len; i++) begin
      if (mode == 0) begin
        vals[i] = $urandom;
      end else begin
        acc = acc + data_t'($urandom_range(0, mode == 1 ? 1 : 1 << 20));
        vals[i] = acc;
      end
    end
    // nearly sorted: swap some neighbor pairs
    i = 0;
    while (mode != 0 && i + 1 < len) begin
      if ($urandom_range(2) == 0) begin
        tmp = vals[i];
        vals[i] = vals[i+1];
        vals[i+1] = tmp;
        i += 2;
      end else begin
        i++;
      end
    end
    for (i = 0; i < len; i++) begin
      send_beat(vals[i], i == len - 1);
    end
  endtask

  initial begin
    int unsigned idle_tab [4];
    int unsigned stall_tab [4];
    int unsigned k_val;
    int unsigned n;
    int unsigned len;
    idle_tab = '{0, 53, 0, 19};
    stall_tab = '{0, 0, 53, 19};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // k = 0: each beat pushes out the one before
    write_k(5'd0);
    send_beat(32'sh7fffffff, 1'b0);
    send_beat(32'sh80000000, 1'b0);
    send_beat(32'sd0, 1'b0);
    send_beat(-32'sd1, 1'b1);
    // k lowered while values are held
    write_k(5'd3);
    send_beat(32'sd10, 1'b0);
    send_beat(32'sd8, 1'b0);
    send_beat(32'sd12, 1'b0);
    send_beat(32'sd9, 1'b0);
    send_beat(32'sd11, 1'b0);
    write_k(5'd1);
    send_beat(32'sd11, 1'b0);
    send_beat(32'sd7, 1'b0);
    send_beat(32'sd11, 1'b0);
    send_beat(32'sd20, 1'b1);
    // single-beat sequence
    write_k(5'd5);
    send_beat(-32'sd5, 1'b1);

    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_tab[p];
      stall_pct = stall_tab[p];
      for (int s = 0; s < 4; s++) begin
        k_val = (s == 0) ? 31 : (s == 1) ? 0 : $urandom_range(31);
        write_k(k_t'(k_val));
        n = 0;
        while (n < 13) begin
          // store saturation and longest drain
          if (k_val == 31 && n == 0) begin
            len = 40;
          end else begin
            len = $urandom_range(1, k_val + 4);
          end
          if ($urandom_range(19) == 0) begin
            drain();
          end
          send_sequence(len);
          n += len;
        end
      end
    end

    drain();
    $display("covered %0d input beats and %0d checked sorted beats over %0d settings of k",
             sent_count, result_count, k_writes);
    $display("k from 0 to 31 incl. full store, mid-sequence k change, four idle/stall mixes");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
design/kss_pkg.sv
design/kss_cell.sv
design/k_sorted_stream_sorter_core.sv
tb/kss_stream_checker.sv
tb/testbench.sv
